/* sv/source_lexer_assert.svh */
// Assertion macros used by the source lexer RTL
`ifndef SOURCE_LEXER_ASSERT_SVH
`define SOURCE_LEXER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define SLEX_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define SLEX_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/slex_pkg.sv */
// Package: token codes, error codes, character constants, operator lookup and byte classes of the source lexer
`default_nettype none

package slex_pkg;

	typedef enum logic [2:0] {
		TK_END   = 3'd0,
		TK_OP    = 3'd1,
		TK_STR   = 3'd2,
		TK_CHR   = 3'd3,
		TK_NUM   = 3'd4,
		TK_IDENT = 3'd5,
		TK_UNK   = 3'd6
	} tok_kind_t;

	typedef enum logic [1:0] {
		ERR_NONE       = 2'd0,
		ERR_UNCLOSED   = 2'd1,
		ERR_BAD_CHAR   = 2'd2,
		ERR_BAD_ESCAPE = 2'd3
	} lex_err_t;

	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_UNDER  = 8'h5F;
	localparam logic [7:0] CH_LOW_N  = 8'h6E;
	localparam logic [7:0] CH_LOW_R  = 8'h72;
	localparam logic [7:0] CH_LOW_S  = 8'h73;
	localparam logic [7:0] CH_LOW_T  = 8'h74;
	localparam logic [7:0] CH_DEL    = 8'h7F;

	localparam logic [4:0] OP_NONE  = 5'd0;
	localparam logic [4:0] OP_SLASH = 5'd15;

	typedef struct packed {
		logic       hit;
		logic [4:0] code;
	} op_hit_t;

	function automatic op_hit_t op_lookup(logic [7:0] b);
		op_hit_t r;
		r.hit = 1'b1;
		case (b)
			8'h40: r.code = 5'd0;   // @
			8'h28: r.code = 5'd1;   // (
			8'h29: r.code = 5'd2;   // )
			8'h5B: r.code = 5'd3;   // [
			8'h5D: r.code = 5'd4;   // ]
			8'h3C: r.code = 5'd5;   // <
			8'h3E: r.code = 5'd6;   // >
			8'h7B: r.code = 5'd7;   // {
			8'h7D: r.code = 5'd8;   // }
			8'h2B: r.code = 5'd9;   // +
			8'h2D: r.code = 5'd10;  // -
			8'h7E: r.code = 5'd11;  // ~
			8'h2E: r.code = 5'd12;  // .
			8'h2C: r.code = 5'd13;  // ,
			8'h2A: r.code = 5'd14;  // *
			8'h2F: r.code = 5'd15;  // /
			8'h5C: r.code = 5'd16;  // backslash
			8'h25: r.code = 5'd17;  // %
			8'h7C: r.code = 5'd18;  // |
			8'h26: r.code = 5'd19;  // &
			8'h5E: r.code = 5'd20;  // ^
			8'h3D: r.code = 5'd21;  // =
			8'h21: r.code = 5'd22;  // !
			8'h3F: r.code = 5'd23;  // ?
			8'h3A: r.code = 5'd24;  // :
			8'h3B: r.code = 5'd25;  // ;
			default: begin
				r.hit  = 1'b0;
				r.code = OP_NONE;
			end
		endcase
		return r;
	endfunction

	function automatic logic is_space(logic [7:0] b);
		return (b == CH_SPACE) || (b >= 8'd9 && b <= 8'd13);
	endfunction

	function automatic logic is_digit(logic [7:0] b);
		return b >= 8'h30 && b <= 8'h39;
	endfunction

	function automatic logic is_word(logic [7:0] b);
		return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A) ||
			(b == CH_UNDER) || (b == CH_DOLLAR);
	endfunction

endpackage

`default_nettype wire

/* sv/source_lexer.sv */
// Streaming source tokenizer: one byte in per cycle while in_stall is low, token descriptors out
//
//   channel | handshake                   | payload
//   --------+-----------------------------+------------------------------------------
//   in      | in_valid / in_stall         | char_byte, end_of_source
//   out     | out_valid / out_stall       | token_kind, operator_code, has_dot,
//           |                             | start_offset/line/column, token_length,
//           |                             | error_code, last
//
// Cycles: a byte is scanned the cycle after it is taken; its 0 to 3 tokens
//   load together into a three-slot result register.
// One byte per cycle while each makes at most one token and out_stall is low; a byte
//   with more holds the next token-making byte until its last leaves. Tokenless bytes never wait.
// Reset and end of source: idle, offset 0, line 1, column 1; reset also empties both registers.
// in_stall follows out_stall in the same cycle while a token-making byte waits on one queued token.
`default_nettype none

module source_lexer
	import slex_pkg::*;
#(
	parameter int OFFSET_WIDTH = 24,
	parameter int COLUMN_WIDTH = 16
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output logic                         in_stall,
	input  wire logic [7:0]              char_byte,
	input  wire logic                    end_of_source,
	output logic                         out_valid,
	input  wire logic                    out_stall,
	output logic [2:0]                   token_kind,
	output logic [4:0]                   operator_code,
	output logic                         has_dot,
	output logic [OFFSET_WIDTH-1:0]      start_offset,
	output logic [OFFSET_WIDTH-1:0]      start_line,
	output logic [COLUMN_WIDTH-1:0]      start_column,
	output logic [COLUMN_WIDTH-1:0]      token_length,
	output logic [1:0]                   error_code,
	output logic                         last
);

`include "source_lexer_assert.svh"

	localparam int OW = OFFSET_WIDTH;
	localparam int CW = COLUMN_WIDTH;

	typedef enum logic [3:0] {
		M_IDLE       = 4'd0,
		M_SLASH      = 4'd1,
		M_COMMENT    = 4'd2,
		M_STRING     = 4'd3,
		M_STRING_ESC = 4'd4,
		M_CHAR_FIRST = 4'd5,
		M_CHAR_ESC   = 4'd6,
		M_NUMBER     = 4'd7,
		M_IDENT      = 4'd8
	} mode_t;

	typedef struct packed {
		tok_kind_t     kind;
		logic [4:0]    op;
		logic          dec;
		logic [OW-1:0] off;
		logic [OW-1:0] line;
		logic [CW-1:0] col;
		logic [CW-1:0] len;
		lex_err_t      err;
	} res_t;

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eos_s1;

	// scanner state
	mode_t         mode_q;
	logic [OW-1:0] off_q, line_q;
	logic [CW-1:0] col_q;
	logic [OW-1:0] st_off_q, st_line_q;
	logic [CW-1:0] st_col_q;
	logic [CW-1:0] len_q;
	logic          dot_q;
	lex_err_t      perr_q;

	// result register: up to three tokens of one byte, slot 0 is shown
	res_t       ent_q [3];
	logic [1:0] cnt_q;

	// next-state and candidate results
	mode_t         n_mode;
	logic [OW-1:0] n_off, n_line;
	logic [CW-1:0] n_col;
	logic [OW-1:0] n_st_off, n_st_line;
	logic [CW-1:0] n_st_col;
	logic [CW-1:0] n_len;
	logic          n_dot;
	lex_err_t      n_perr;
	res_t          cand [4];
	logic [3:0]    cv;
	res_t          slot [3];
	logic [1:0]    n_res;
	logic          do_idle;
	op_hit_t       oph;
	lex_err_t      esc_err;

	logic go, in_fire, out_fire;

	function automatic logic [OW-1:0] sat_ow(logic [OW-1:0] v);
		return (&v) ? v : v + 1'b1;
	endfunction

	function automatic logic [CW-1:0] sat_cw(logic [CW-1:0] v);
		return (&v) ? v : v + 1'b1;
	endfunction

	function automatic res_t mk(tok_kind_t k, logic [4:0] op, logic dec,
		logic [OW-1:0] off, logic [OW-1:0] ln, logic [CW-1:0] col,
		logic [CW-1:0] len, lex_err_t err);
		res_t r;
		r.kind = k;
		r.op   = op;
		r.dec  = dec;
		r.off  = off;
		r.line = ln;
		r.col  = col;
		r.len  = len;
		r.err  = err;
		return r;
	endfunction

	// Candidate order: [0] token closed by this byte, [1] one-byte token started
	// by it, [2] pending token flushed at end of source, [3] end token.
	always_comb begin
		n_mode    = mode_q;
		n_st_off  = st_off_q;
		n_st_line = st_line_q;
		n_st_col  = st_col_q;
		n_len     = len_q;
		n_dot     = dot_q;
		n_perr    = perr_q;
		do_idle   = 1'b0;
		cv        = '0;
		for (int k = 0; k < 4; k++) begin
			cand[k] = '0;
		end
		oph     = op_lookup(byte_s1);
		esc_err = ERR_NONE;

		if (perr_q == ERR_NONE) begin
			case (mode_q)
				M_SLASH: begin
					if (byte_s1 == CH_SLASH) begin
						n_mode = M_COMMENT;
					end else begin
						cv[0]   = 1'b1;
						cand[0] = mk(TK_OP, OP_SLASH, 1'b0, st_off_q, st_line_q, st_col_q,
							len_q, ERR_NONE);
						n_mode  = M_IDLE;
						do_idle = 1'b1;
					end
				end
				M_COMMENT: begin
					if (byte_s1 == CH_NL) begin
						n_mode = M_IDLE;
					end
				end
				M_STRING: begin
					n_len = sat_cw(len_q);
					if (byte_s1 == CH_DQUOTE) begin
						cv[0]   = 1'b1;
						cand[0] = mk(TK_STR, OP_NONE, 1'b0, st_off_q, st_line_q, st_col_q,
							n_len, ERR_NONE);
						n_mode  = M_IDLE;
					end else if (byte_s1 == CH_BSLASH) begin
						n_mode = M_STRING_ESC;
					end
				end
				M_STRING_ESC: begin
					n_len  = sat_cw(len_q);
					n_mode = M_STRING;
				end
				M_CHAR_FIRST: begin
					// literal starts after the quote
					n_st_off  = off_q;
					n_st_line = line_q;
					n_st_col  = col_q;
					n_len     = CW'(1);
					if (is_space(byte_s1) || byte_s1 < CH_SPACE || byte_s1 == CH_DEL) begin
						cv[0]   = 1'b1;
						cand[0] = mk(TK_CHR, OP_NONE, 1'b0, off_q, line_q, col_q,
							CW'(1), ERR_BAD_CHAR);
						n_perr  = ERR_BAD_CHAR;
						n_mode  = M_IDLE;
					end else if (byte_s1 == CH_BSLASH) begin
						n_len  = CW'(2);
						n_mode = M_CHAR_ESC;
					end else begin
						cv[0]   = 1'b1;
						cand[0] = mk(TK_CHR, OP_NONE, 1'b0, off_q, line_q, col_q,
							CW'(1), ERR_NONE);
						n_mode  = M_IDLE;
					end
				end
				M_CHAR_ESC: begin
					if (byte_s1 == CH_LOW_R || byte_s1 == CH_LOW_N ||
						byte_s1 == CH_LOW_T || byte_s1 == CH_LOW_S) begin
						esc_err = ERR_NONE;
					end else begin
						esc_err = ERR_BAD_ESCAPE;
					end
					cv[0]   = 1'b1;
					cand[0] = mk(TK_CHR, OP_NONE, 1'b0, st_off_q, st_line_q, st_col_q,
						len_q, esc_err);
					n_perr  = esc_err;
					n_mode  = M_IDLE;
				end
				M_NUMBER: begin
					if (is_digit(byte_s1)) begin
						n_len = sat_cw(len_q);
					end else if (byte_s1 == CH_DOT && !dot_q) begin
						n_dot = 1'b1;
						n_len = sat_cw(len_q);
					end else begin
						cv[0]   = 1'b1;
						cand[0] = mk(TK_NUM, OP_NONE, dot_q, st_off_q, st_line_q, st_col_q,
							len_q, ERR_NONE);
						n_mode  = M_IDLE;
						do_idle = 1'b1;
					end
				end
				M_IDENT: begin
					if (is_word(byte_s1) || is_digit(byte_s1)) begin
						n_len = sat_cw(len_q);
					end else begin
						cv[0]   = 1'b1;
						cand[0] = mk(TK_IDENT, OP_NONE, 1'b0, st_off_q, st_line_q, st_col_q,
							len_q, ERR_NONE);
						n_mode  = M_IDLE;
						do_idle = 1'b1;
					end
				end
				default: begin
					n_mode  = M_IDLE;
					do_idle = 1'b1;
				end
			endcase

			// byte seen between tokens, also the terminator of a closed token
			if (do_idle && !is_space(byte_s1)) begin
				if (oph.hit && byte_s1 != CH_SLASH) begin
					cv[1]   = 1'b1;
					cand[1] = mk(TK_OP, oph.code, 1'b0, off_q, line_q, col_q, CW'(1), ERR_NONE);
				end else if (oph.hit || byte_s1 == CH_DQUOTE || byte_s1 == CH_SQUOTE ||
					is_digit(byte_s1) || is_word(byte_s1)) begin
					n_st_off  = off_q;
					n_st_line = line_q;
					n_st_col  = col_q;
					n_len     = CW'(1);
					if (oph.hit) begin
						n_mode = M_SLASH;
					end else if (byte_s1 == CH_DQUOTE) begin
						n_mode = M_STRING;
					end else if (byte_s1 == CH_SQUOTE) begin
						n_mode = M_CHAR_FIRST;
					end else if (is_digit(byte_s1)) begin
						n_dot  = 1'b0;
						n_mode = M_NUMBER;
					end else begin
						n_mode = M_IDENT;
					end
				end else begin
					cv[1]   = 1'b1;
					cand[1] = mk(TK_UNK, OP_NONE, 1'b0, off_q, line_q, col_q, CW'(1), ERR_NONE);
				end
			end
		end

		// position advance, saturating
		n_off = sat_ow(off_q);
		if (byte_s1 == CH_NL) begin
			n_line = sat_ow(line_q);
			n_col  = CW'(1);
		end else begin
			n_line = line_q;
			n_col  = sat_cw(col_q);
		end

		if (eos_s1) begin
			if (n_perr == ERR_NONE) begin
				case (n_mode)
					M_SLASH: begin
						cv[2]   = 1'b1;
						cand[2] = mk(TK_OP, OP_SLASH, 1'b0, n_st_off, n_st_line, n_st_col,
							n_len, ERR_NONE);
					end
					M_NUMBER: begin
						cv[2]   = 1'b1;
						cand[2] = mk(TK_NUM, OP_NONE, n_dot, n_st_off, n_st_line, n_st_col,
							n_len, ERR_NONE);
					end
					M_IDENT: begin
						cv[2]   = 1'b1;
						cand[2] = mk(TK_IDENT, OP_NONE, 1'b0, n_st_off, n_st_line, n_st_col,
							n_len, ERR_NONE);
					end
					M_STRING, M_STRING_ESC: begin
						cv[2]   = 1'b1;
						cand[2] = mk(TK_STR, OP_NONE, 1'b0, n_st_off, n_st_line, n_st_col,
							n_len, ERR_UNCLOSED);
					end
					M_CHAR_FIRST: begin
						cv[2]   = 1'b1;
						cand[2] = mk(TK_CHR, OP_NONE, 1'b0, n_off, n_line, n_col,
							'0, ERR_BAD_CHAR);
					end
					M_CHAR_ESC: begin
						cv[2]   = 1'b1;
						cand[2] = mk(TK_CHR, OP_NONE, 1'b0, n_st_off, n_st_line, n_st_col,
							CW'(1), ERR_BAD_ESCAPE);
					end
					default: begin
					end
				endcase
			end
			cv[3]   = 1'b1;
			cand[3] = mk(TK_END, OP_NONE, 1'b0, n_off, n_line, n_col, '0, ERR_NONE);

			// back to the reset state for the next source
			n_mode    = M_IDLE;
			n_off     = '0;
			n_line    = OW'(1);
			n_col     = CW'(1);
			n_st_off  = '0;
			n_st_line = OW'(1);
			n_st_col  = CW'(1);
			n_len     = '0;
			n_dot     = 1'b0;
			n_perr    = ERR_NONE;
		end
	end

	// pack the valid candidates into the result slots, in order
	always_comb begin
		n_res = 2'd0;
		for (int k = 0; k < 3; k++) begin
			slot[k] = '0;
		end
		for (int k = 0; k < 4; k++) begin
			if (cv[k] && n_res != 2'd3) begin
				slot[n_res] = cand[k];
				n_res       = n_res + 2'd1;
			end
		end
	end

	assign out_fire = out_valid && !out_stall;
	// a byte retires when it makes no token or the slots are free by this edge
	assign go       = valid_s1 &&
		(n_res == 2'd0 || cnt_q == 2'd0 || (cnt_q == 2'd1 && out_fire));
	assign in_stall = valid_s1 && !go;
	assign in_fire  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			byte_s1   <= '0;
			eos_s1    <= 1'b0;
			mode_q    <= M_IDLE;
			off_q     <= '0;
			line_q    <= OW'(1);
			col_q     <= CW'(1);
			st_off_q  <= '0;
			st_line_q <= OW'(1);
			st_col_q  <= CW'(1);
			len_q     <= '0;
			dot_q     <= 1'b0;
			perr_q    <= ERR_NONE;
			cnt_q     <= 2'd0;
			for (int k = 0; k < 3; k++) begin
				ent_q[k] <= '0;
			end
		end else begin
			if (in_fire) begin
				byte_s1 <= char_byte;
				eos_s1  <= end_of_source;
			end
			valid_s1 <= in_fire || (valid_s1 && !go);

			if (go) begin
				mode_q    <= n_mode;
				off_q     <= n_off;
				line_q    <= n_line;
				col_q     <= n_col;
				st_off_q  <= n_st_off;
				st_line_q <= n_st_line;
				st_col_q  <= n_st_col;
				len_q     <= n_len;
				dot_q     <= n_dot;
				perr_q    <= n_perr;
			end

			if (go && n_res != 2'd0) begin
				ent_q[0] <= slot[0];
				ent_q[1] <= slot[1];
				ent_q[2] <= slot[2];
				cnt_q    <= n_res;
			end else if (out_fire) begin
				ent_q[0] <= ent_q[1];
				ent_q[1] <= ent_q[2];
				cnt_q    <= cnt_q - 2'd1;
			end
		end
	end

	assign out_valid     = cnt_q != 2'd0;
	assign token_kind    = ent_q[0].kind;
	assign operator_code = ent_q[0].op;
	assign has_dot       = ent_q[0].dec;
	assign start_offset  = ent_q[0].off;
	assign start_line    = ent_q[0].line;
	assign start_column  = ent_q[0].col;
	assign token_length  = ent_q[0].len;
	assign error_code    = ent_q[0].err;
	// the slots only ever hold one byte's tokens
	assign last          = cnt_q == 2'd1;

	`SLEX_ASSERT_NEXT(a_load_count, go && n_res != 2'd0, cnt_q == $past(n_res), "slot count mismatch")
	`SLEX_ASSERT_NOW(a_err_quiet, valid_s1 && perr_q != ERR_NONE, n_res == {1'b0, eos_s1}, "token after error")
	`SLEX_ASSERT_NOW(a_end_last, out_valid && token_kind == TK_END, last, "end token not last")
	`SLEX_ASSERT_NOW(a_pos_nonzero, 1'b1, line_q != '0 && col_q != '0 && st_line_q != '0, "zero line or column")

endmodule

`default_nettype wire
